// ===== rtl/crp_pkg.sv =====
// Shared types, constants, tables and helpers of the posterize and style remap pipeline.
package crp_pkg;

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_MODE_SELECT = 2'd0;
   localparam logic [1:0] CSR_QUANT_BANDS = 2'd1;
   localparam logic [1:0] CSR_STYLE_INDEX = 2'd2;

   // Register reset values
   localparam logic       MODE_RESET  = 1'b0;
   localparam logic [7:0] BANDS_RESET = 8'd4;
   localparam logic [2:0] STYLE_RESET = 3'd0;

   // Mode codes
   localparam logic MODE_POSTERIZE = 1'b0;
   localparam logic MODE_STYLE     = 1'b1;

   // Band count limits
   localparam logic [7:0] BANDS_MIN = 8'd2;
   localparam logic [7:0] BANDS_MAX = 8'd8;

   // Style table: classic, anime, comic, watercolor, retro
   localparam int STYLE_COUNT = 5;
   localparam logic [8:0]        STYLE_SAT    [STYLE_COUNT] = '{9'd256, 9'd332, 9'd358,
                                                              9'd192, 9'd230};
   localparam logic signed [7:0] STYLE_WARMTH [STYLE_COUNT] = '{8'sd0, -8'sd26, 8'sd13,
                                                              8'sd38, 8'sd77};
   // Band count minus one per style
   localparam logic [2:0]        STYLE_NM1    [STYLE_COUNT] = '{3'd3, 3'd2, 3'd2,
                                                              3'd5, 3'd3};

   // Luma weights
   localparam logic [7:0] LUMA_R = 8'd77;
   localparam logic [7:0] LUMA_G = 8'd150;
   localparam logic [7:0] LUMA_B = 8'd29;

   // Warmth weights
   localparam logic signed [11:0] WARM_RB = 12'sd15;
   localparam logic signed [11:0] WARM_G  = 12'sd5;

   // Level table: entry {nm1, idx} holds idx*255/nm1, truncated
   localparam logic [7:0] LEVEL_TABLE [64] = '{
      8'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0, 8'd127, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0, 8'd85,  8'd170, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
      8'd0, 8'd63,  8'd127, 8'd191, 8'd255, 8'd0,   8'd0,   8'd0,
      8'd0, 8'd51,  8'd102, 8'd153, 8'd204, 8'd255, 8'd0,   8'd0,
      8'd0, 8'd42,  8'd85,  8'd127, 8'd170, 8'd212, 8'd255, 8'd0,
      8'd0, 8'd36,  8'd72,  8'd109, 8'd145, 8'd182, 8'd218, 8'd255
   };

   // Per-word control that travels with the pixel
   typedef struct packed {
      logic              mode;
      logic [2:0]        nm1;
      logic [8:0]        sat;
      logic signed [3:0] w15;
      logic signed [2:0] w5;
   } ctl_type;

   // Band index by rounded scale, then back to a level; x/255 via reciprocal
   function automatic logic [7:0] posterize(input logic [7:0] v, input logic [2:0] nm1);
      logic [10:0] x;
      logic [10:0] y;
      logic [2:0]  idx;
      x = 11'(v) * 11'(nm1) + 11'd127;
      y = x + 11'(x[10:8]) + 11'd1;
      idx = y[10:8];
      if (idx > nm1) begin
         idx = nm1;
      end
      return LEVEL_TABLE[{nm1, idx}];
   endfunction

   // Red/blue warmth offset, floored
   function automatic logic signed [3:0] warm_rb(input logic signed [7:0] warmth);
      logic signed [11:0] p;
      p = 12'(warmth) * WARM_RB;
      return p[11:8];
   endfunction

   // Green warmth offset, floored
   function automatic logic signed [2:0] warm_g(input logic signed [7:0] warmth);
      logic signed [11:0] p;
      p = 12'(warmth) * WARM_G;
      return p[10:8];
   endfunction

endpackage

// ===== rtl/crp_quant.sv =====
// Posterize stage: reduces each color channel to its band level.
module crp_quant (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_in,
   output logic             ready_out,
   input  logic             ready_in,
   input  logic [7:0]       red_in,
   input  logic [7:0]       green_in,
   input  logic [7:0]       blue_in,
   input  logic [7:0]       alpha_in,
   input  crp_pkg::ctl_type ctl_in,
   output logic             valid_ff,
   output logic [7:0]       red_ff,
   output logic [7:0]       green_ff,
   output logic [7:0]       blue_ff,
   output logic [7:0]       alpha_ff,
   output crp_pkg::ctl_type ctl_ff
);

   logic [7:0] red_q_in;
   logic [7:0] green_q_in;
   logic [7:0] blue_q_in;

   // Take a word when empty or when the next stage moves
   assign ready_out = !valid_ff || ready_in;

   // Map channels to levels
   always_comb begin
      red_q_in   = crp_pkg::posterize(red_in, ctl_in.nm1);
      green_q_in = crp_pkg::posterize(green_in, ctl_in.nm1);
      blue_q_in  = crp_pkg::posterize(blue_in, ctl_in.nm1);
   end

   // Advance valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   // Load payload
   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         red_ff   <= red_q_in;
         green_ff <= green_q_in;
         blue_ff  <= blue_q_in;
         alpha_ff <= alpha_in;
         ctl_ff   <= ctl_in;
      end
   end

endmodule

// ===== rtl/crp_chroma.sv =====
// Luma and saturation stages: forms luma, then scales each channel away from it.
module crp_chroma (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_in,
   output logic                ready_out,
   input  logic                ready_in,
   input  logic [7:0]          red_in,
   input  logic [7:0]          green_in,
   input  logic [7:0]          blue_in,
   input  logic [7:0]          alpha_in,
   input  crp_pkg::ctl_type    ctl_in,
   output logic                valid_ff,
   output logic [7:0]          red_ff,
   output logic [7:0]          green_ff,
   output logic [7:0]          blue_ff,
   output logic [7:0]          alpha_ff,
   output logic [7:0]          luma_ff,
   output logic signed [9:0]   red_sc_ff,
   output logic signed [9:0]   green_sc_ff,
   output logic signed [9:0]   blue_sc_ff,
   output crp_pkg::ctl_type    ctl_ff
);

   // Luma stage registers
   logic             lu_valid_ff;
   logic             lu_ready;
   logic [7:0]       lu_red_ff;
   logic [7:0]       lu_green_ff;
   logic [7:0]       lu_blue_ff;
   logic [7:0]       lu_alpha_ff;
   logic [7:0]       lu_luma_ff;
   crp_pkg::ctl_type lu_ctl_ff;

   logic [15:0]        luma_sum;
   logic [7:0]         luma_in;
   logic signed [8:0]  red_diff;
   logic signed [8:0]  green_diff;
   logic signed [8:0]  blue_diff;
   logic signed [18:0] red_prod;
   logic signed [18:0] green_prod;
   logic signed [18:0] blue_prod;
   logic signed [18:0] sat_gain;

   assign ready_out = !lu_valid_ff || lu_ready;
   assign lu_ready  = !valid_ff || ready_in;

   // Weighted luma sum
   always_comb begin
      luma_sum = 16'(red_in) * 16'(crp_pkg::LUMA_R)
               + 16'(green_in) * 16'(crp_pkg::LUMA_G)
               + 16'(blue_in) * 16'(crp_pkg::LUMA_B);
      luma_in  = luma_sum[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lu_valid_ff <= 1'b0;
      end else if (ready_out) begin
         lu_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         lu_red_ff   <= red_in;
         lu_green_ff <= green_in;
         lu_blue_ff  <= blue_in;
         lu_alpha_ff <= alpha_in;
         lu_luma_ff  <= luma_in;
         lu_ctl_ff   <= ctl_in;
      end
   end

   // Scale the offset from luma by the unsigned 1.8 gain; bit select floors
   always_comb begin
      red_diff   = $signed({1'b0, lu_red_ff}) - $signed({1'b0, lu_luma_ff});
      green_diff = $signed({1'b0, lu_green_ff}) - $signed({1'b0, lu_luma_ff});
      blue_diff  = $signed({1'b0, lu_blue_ff}) - $signed({1'b0, lu_luma_ff});
      sat_gain   = 19'($signed({1'b0, lu_ctl_ff.sat}));
      red_prod   = 19'(red_diff) * sat_gain;
      green_prod = 19'(green_diff) * sat_gain;
      blue_prod  = 19'(blue_diff) * sat_gain;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (lu_ready) begin
         valid_ff <= lu_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lu_ready && lu_valid_ff) begin
         red_ff      <= lu_red_ff;
         green_ff    <= lu_green_ff;
         blue_ff     <= lu_blue_ff;
         alpha_ff    <= lu_alpha_ff;
         luma_ff     <= lu_luma_ff;
         red_sc_ff   <= red_prod[17:8];
         green_sc_ff <= green_prod[17:8];
         blue_sc_ff  <= blue_prod[17:8];
         ctl_ff      <= lu_ctl_ff;
      end
   end

endmodule

// ===== rtl/crp_finish.sv =====
// Output stage: adds warmth, clamps, selects by mode and holds the result word.
module crp_finish (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_in,
   output logic              ready_out,
   input  logic              stall_in,
   input  logic [7:0]        red_in,
   input  logic [7:0]        green_in,
   input  logic [7:0]        blue_in,
   input  logic [7:0]        alpha_in,
   input  logic [7:0]        luma_in,
   input  logic signed [9:0] red_sc_in,
   input  logic signed [9:0] green_sc_in,
   input  logic signed [9:0] blue_sc_in,
   input  crp_pkg::ctl_type  ctl_in,
   output logic              valid_ff,
   output logic [7:0]        red_ff,
   output logic [7:0]        green_ff,
   output logic [7:0]        blue_ff,
   output logic [7:0]        alpha_ff
);

   logic signed [11:0] red_sum;
   logic signed [11:0] green_sum;
   logic signed [11:0] blue_sum;
   logic signed [11:0] luma_ext;
   logic [7:0]         red_res_in;
   logic [7:0]         green_res_in;
   logic [7:0]         blue_res_in;

   function automatic logic [7:0] clamp8(input logic signed [11:0] v);
      logic [7:0] r;
      if (v < 12'sd0) begin
         r = 8'd0;
      end else if (v > 12'sd255) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   assign ready_out = !valid_ff || !stall_in;

   // Add warmth and clamp, or pass posterized levels
   always_comb begin
      luma_ext  = $signed({4'b0, luma_in});
      red_sum   = luma_ext + 12'(red_sc_in) + 12'(ctl_in.w15);
      green_sum = luma_ext + 12'(green_sc_in) + 12'(ctl_in.w5);
      blue_sum  = luma_ext + 12'(blue_sc_in) - 12'(ctl_in.w15);
      if (ctl_in.mode == crp_pkg::MODE_STYLE) begin
         red_res_in   = clamp8(red_sum);
         green_res_in = clamp8(green_sum);
         blue_res_in  = clamp8(blue_sum);
      end else begin
         red_res_in   = red_in;
         green_res_in = green_in;
         blue_res_in  = blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= valid_in;
      end
   end

   // Hold the word while stalled
   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         red_ff   <= red_res_in;
         green_ff <= green_res_in;
         blue_ff  <= blue_res_in;
         alpha_ff <= alpha_in;
      end
   end

endmodule

// ===== rtl/color_posterize_style_remap.sv =====
// A word accepted on req_ passes five register stages on its way to rsp_.
// Throughput: one word per clock unless rsp_stall holds; only the ready chain bounds it.
// Stages: input register, posterize, luma, saturation multiply, warmth/clamp output.
// Reset (synchronous, active high) empties the pipeline and sets mode_select 0,
// quant_bands 4, style_index 0.
// Top level: CSR registers, per-word control decode, input stage and stage chain.
module color_posterize_style_remap (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_alpha_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_alpha_out
);

   // Configuration registers
   logic       mode_ff;
   logic [7:0] bands_ff;
   logic [2:0] style_ff;

   // Input stage
   logic             in_valid_ff;
   logic             in_ready;
   logic [7:0]       in_red_ff;
   logic [7:0]       in_green_ff;
   logic [7:0]       in_blue_ff;
   logic [7:0]       in_alpha_ff;
   crp_pkg::ctl_type in_ctl_ff;
   crp_pkg::ctl_type ctl_in;

   // Posterize stage outputs
   logic             qu_valid;
   logic             qu_ready;
   logic [7:0]       qu_red;
   logic [7:0]       qu_green;
   logic [7:0]       qu_blue;
   logic [7:0]       qu_alpha;
   crp_pkg::ctl_type qu_ctl;

   // Chroma stage outputs
   logic              ch_valid;
   logic              ch_ready;
   logic [7:0]        ch_red;
   logic [7:0]        ch_green;
   logic [7:0]        ch_blue;
   logic [7:0]        ch_alpha;
   logic [7:0]        ch_luma;
   logic signed [9:0] ch_red_sc;
   logic signed [9:0] ch_green_sc;
   logic signed [9:0] ch_blue_sc;
   crp_pkg::ctl_type  ch_ctl;

   logic [2:0] style_sel;
   logic [7:0] bands_clamped;

   // Write CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= crp_pkg::MODE_RESET;
         bands_ff <= crp_pkg::BANDS_RESET;
         style_ff <= crp_pkg::STYLE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            crp_pkg::CSR_MODE_SELECT: mode_ff  <= csr_write_data[0];
            crp_pkg::CSR_QUANT_BANDS: bands_ff <= csr_write_data;
            crp_pkg::CSR_STYLE_INDEX: style_ff <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // Decode per-word control from the registers
   always_comb begin
      style_sel = (style_ff < 3'(crp_pkg::STYLE_COUNT)) ? style_ff : 3'd0;
      if (bands_ff < crp_pkg::BANDS_MIN) begin
         bands_clamped = crp_pkg::BANDS_MIN;
      end else if (bands_ff > crp_pkg::BANDS_MAX) begin
         bands_clamped = crp_pkg::BANDS_MAX;
      end else begin
         bands_clamped = bands_ff;
      end
      ctl_in.mode = mode_ff;
      ctl_in.sat  = crp_pkg::STYLE_SAT[style_sel];
      ctl_in.w15  = crp_pkg::warm_rb(crp_pkg::STYLE_WARMTH[style_sel]);
      ctl_in.w5   = crp_pkg::warm_g(crp_pkg::STYLE_WARMTH[style_sel]);
      if (mode_ff == crp_pkg::MODE_STYLE) begin
         ctl_in.nm1 = crp_pkg::STYLE_NM1[style_sel];
      end else begin
         ctl_in.nm1 = 3'(bands_clamped - 8'd1);
      end
   end

   // Input stage handshake
   assign in_ready  = !in_valid_ff || qu_ready;
   assign req_stall = !in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_red_ff   <= req_red_in;
         in_green_ff <= req_green_in;
         in_blue_ff  <= req_blue_in;
         in_alpha_ff <= req_alpha_in;
         in_ctl_ff   <= ctl_in;
      end
   end

   crp_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (in_valid_ff),
      .ready_out (qu_ready),
      .ready_in  (ch_ready),
      .red_in    (in_red_ff),
      .green_in  (in_green_ff),
      .blue_in   (in_blue_ff),
      .alpha_in  (in_alpha_ff),
      .ctl_in    (in_ctl_ff),
      .valid_ff  (qu_valid),
      .red_ff    (qu_red),
      .green_ff  (qu_green),
      .blue_ff   (qu_blue),
      .alpha_ff  (qu_alpha),
      .ctl_ff    (qu_ctl)
   );

   logic fi_ready;

   crp_chroma u_chroma (
      .clock       (clock),
      .reset       (reset),
      .valid_in    (qu_valid),
      .ready_out   (ch_ready),
      .ready_in    (fi_ready),
      .red_in      (qu_red),
      .green_in    (qu_green),
      .blue_in     (qu_blue),
      .alpha_in    (qu_alpha),
      .ctl_in      (qu_ctl),
      .valid_ff    (ch_valid),
      .red_ff      (ch_red),
      .green_ff    (ch_green),
      .blue_ff     (ch_blue),
      .alpha_ff    (ch_alpha),
      .luma_ff     (ch_luma),
      .red_sc_ff   (ch_red_sc),
      .green_sc_ff (ch_green_sc),
      .blue_sc_ff  (ch_blue_sc),
      .ctl_ff      (ch_ctl)
   );

   crp_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .valid_in    (ch_valid),
      .ready_out   (fi_ready),
      .stall_in    (rsp_stall),
      .red_in      (ch_red),
      .green_in    (ch_green),
      .blue_in     (ch_blue),
      .alpha_in    (ch_alpha),
      .luma_in     (ch_luma),
      .red_sc_in   (ch_red_sc),
      .green_sc_in (ch_green_sc),
      .blue_sc_in  (ch_blue_sc),
      .ctl_in      (ch_ctl),
      .valid_ff    (rsp_valid),
      .red_ff      (rsp_red_out),
      .green_ff    (rsp_green_out),
      .blue_ff     (rsp_blue_out),
      .alpha_ff    (rsp_alpha_out)
   );

endmodule
